@@ rtl/core/text_terminal_writer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal writer
// Immediate-implication and next-cycle checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

// hold cond in the same cycle as trig
`define TTW_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// hold cond in the cycle after trig
`define TTW_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/core/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text terminal writer package
// Screen geometry, cell constants, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ttw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TEXT_ROWS  = 24;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int OP_W    = 3;
	localparam int CHAR_W  = 8;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;

	localparam int SCROLL_COPY = (TEXT_ROWS - 1) * COLUMNS;
	localparam int SCROLL_END  = TEXT_ROWS * COLUMNS;

	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(SCROLL_END - 1);

	localparam logic [CELL_W-1:0]  BLANK_CELL    = 16'h0720;
	localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h07;
	localparam logic [CHAR_W-1:0]  CH_NEWLINE    = 8'd10;
	localparam logic [CHAR_W-1:0]  CH_RETURN     = 8'd13;
	localparam logic [CHAR_W-1:0]  CH_SPACE      = 8'd32;

	localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
	localparam logic [OP_W-1:0] OP_PUT_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_COLOR = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
	localparam logic [OP_W-1:0] OP_READ      = 3'd5;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_CLEAR,
		ST_RESP
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(int'(row) * COLUMNS + int'(col));
	endfunction

	function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] color);
		return {color, ch};
	endfunction

endpackage

@@ rtl/core/ttw_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready handshake carrying one terminal operation.
// ----------------------------------------------------------------------------
interface ttw_req_if;
	logic                          valid;
	logic                          ready;
	logic [ttw_pkg::OP_W-1:0]      operation;
	logic [ttw_pkg::CHAR_W-1:0]    char_code;
	logic [ttw_pkg::ROW_W-1:0]     cell_row;
	logic [ttw_pkg::COL_W-1:0]     cell_col;
	logic [ttw_pkg::COLOR_W-1:0]   color_value;

	modport source (output valid, operation, char_code, cell_row, cell_col, color_value,
		input ready);
	modport sink (input valid, operation, char_code, cell_row, cell_col, color_value,
		output ready);
endinterface

@@ rtl/core/ttw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready handshake carrying the cell read and cursor after a request.
// ----------------------------------------------------------------------------
interface ttw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ttw_pkg::CELL_W-1:0]   cell_data;
	logic [ttw_pkg::ROW_W-1:0]    cursor_row;
	logic [ttw_pkg::COL_W-1:0]    cursor_col;
	logic                         out_of_range;

	modport source (output valid, cell_data, cursor_row, cursor_col, out_of_range,
		input ready);
	modport sink (input valid, cell_data, cursor_row, cursor_col, out_of_range,
		output ready);
endinterface

@@ rtl/core/ttw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// Text terminal writer: a request passes through accept, execute and respond, with a read
// state for an on-screen read; a scroll copies 1840 cells up a row and writes spaces to
// row 23 via the one RAM port pair. Clear and reset blank all 2000 cells, with ready low.
// Reset clears the cursor to 0,0 and the color to light grey on black.
// ----------------------------------------------------------------------------
`include "text_terminal_writer_assert.svh"

module text_terminal_writer (
	input  logic        clk,
	input  logic        arst_n,
	ttw_req_if.sink     req,
	ttw_rsp_if.source   rsp
);

	ttw_pkg::state_t st_q, st_d;

	logic [ttw_pkg::OP_W-1:0]    op_q;
	logic [ttw_pkg::CHAR_W-1:0]  char_q;
	logic [ttw_pkg::ROW_W-1:0]   row_q;
	logic [ttw_pkg::COL_W-1:0]   col_q;
	logic [ttw_pkg::COLOR_W-1:0] color_in_q;

	logic [ttw_pkg::ROW_W-1:0]   cursor_row_q, cursor_row_d;
	logic [ttw_pkg::COL_W-1:0]   cursor_col_q, cursor_col_d;
	logic [ttw_pkg::COLOR_W-1:0] color_q, color_d;
	logic [ttw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
	logic [ttw_pkg::CELL_W-1:0]  data_q, data_d;
	logic                        oor_q, oor_d;

	logic                        out_valid_q;
	logic [ttw_pkg::CELL_W-1:0]  out_data_q;
	logic [ttw_pkg::ROW_W-1:0]   out_row_q;
	logic [ttw_pkg::COL_W-1:0]   out_col_q;
	logic                        out_oor_q;

	logic                        ram_we, ram_re;
	logic [ttw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [ttw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

	logic                        on_screen, scroll_go, load_rsp, scroll_copy;
	logic [ttw_pkg::ROW_W-1:0]   row_inc, bs_row;
	logic [ttw_pkg::COL_W-1:0]   bs_col;

	assign on_screen = ({1'b0, row_q} < (ttw_pkg::ROW_W + 1)'(ttw_pkg::ROWS))
		&& ({1'b0, col_q} < (ttw_pkg::COL_W + 1)'(ttw_pkg::COLUMNS));
	assign row_inc = cursor_row_q + 1'b1;
	assign scroll_copy = ({1'b0, cnt_q} < (ttw_pkg::ADDR_W + 1)'(ttw_pkg::SCROLL_COPY));
	assign load_rsp = (st_q == ttw_pkg::ST_RESP) && (!out_valid_q || rsp.ready);

	assign req.ready = (st_q == ttw_pkg::ST_IDLE);

	always_comb begin
		bs_row = cursor_row_q;
		bs_col = cursor_col_q - 1'b1;
		if (cursor_col_q == '0) begin
			bs_row = cursor_row_q - 1'b1;
			bs_col = ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1);
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ttw_pkg::ST_BOOT: begin
				if (cnt_q == ttw_pkg::LAST_CELL) begin
					st_d = ttw_pkg::ST_IDLE;
				end
			end
			ttw_pkg::ST_IDLE: begin
				if (req.valid) begin
					st_d = ttw_pkg::ST_EXEC;
				end
			end
			ttw_pkg::ST_EXEC: begin
				if (scroll_go) begin
					st_d = ttw_pkg::ST_SCR_RD;
				end else if (op_q == ttw_pkg::OP_CLEAR) begin
					st_d = ttw_pkg::ST_CLEAR;
				end else if (op_q == ttw_pkg::OP_READ && on_screen) begin
					st_d = ttw_pkg::ST_READ;
				end else begin
					st_d = ttw_pkg::ST_RESP;
				end
			end
			ttw_pkg::ST_READ: begin
				st_d = ttw_pkg::ST_RESP;
			end
			ttw_pkg::ST_SCR_RD: begin
				st_d = ttw_pkg::ST_SCR_WR;
			end
			ttw_pkg::ST_SCR_WR: begin
				st_d = (cnt_q == ttw_pkg::SCROLL_LAST) ? ttw_pkg::ST_RESP : ttw_pkg::ST_SCR_RD;
			end
			ttw_pkg::ST_CLEAR: begin
				if (cnt_q == ttw_pkg::LAST_CELL) begin
					st_d = ttw_pkg::ST_RESP;
				end
			end
			ttw_pkg::ST_RESP: begin
				if (load_rsp) begin
					st_d = ttw_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = ttw_pkg::ST_BOOT;
			end
		endcase
	end

	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = cnt_q;
		ram_wdata    = ttw_pkg::BLANK_CELL;
		ram_re       = 1'b0;
		ram_raddr    = cnt_q + ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS);
		cursor_row_d = cursor_row_q;
		cursor_col_d = cursor_col_q;
		color_d      = color_q;
		cnt_d        = cnt_q;
		data_d       = data_q;
		oor_d        = oor_q;
		scroll_go    = 1'b0;
		unique case (st_q) inside
			ttw_pkg::ST_BOOT, ttw_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
			end
			ttw_pkg::ST_EXEC: begin
				cnt_d  = '0;
				data_d = '0;
				oor_d  = 1'b0;
				unique case (op_q)
					ttw_pkg::OP_PUT_CHAR: begin
						if (char_q == ttw_pkg::CH_NEWLINE) begin
							cursor_col_d = '0;
							cursor_row_d = row_inc;
						end else if (char_q == ttw_pkg::CH_RETURN) begin
							cursor_col_d = '0;
						end else begin
							ram_we    = ({1'b0, cursor_row_q}
								< (ttw_pkg::ROW_W + 1)'(ttw_pkg::ROWS));
							ram_waddr = ttw_pkg::cell_addr(cursor_row_q, cursor_col_q);
							ram_wdata = ttw_pkg::make_cell(char_q, color_q);
							if (cursor_col_q == ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1)) begin
								cursor_col_d = '0;
								cursor_row_d = row_inc;
							end else begin
								cursor_col_d = cursor_col_q + 1'b1;
							end
						end
						if (({1'b0, cursor_row_d} >= (ttw_pkg::ROW_W + 1)'(ttw_pkg::TEXT_ROWS))) begin
							cursor_row_d = ttw_pkg::ROW_W'(ttw_pkg::TEXT_ROWS - 1);
							scroll_go    = 1'b1;
						end
					end
					ttw_pkg::OP_BACKSPACE: begin
						if (cursor_col_q != '0 || cursor_row_q != '0) begin
							cursor_row_d = bs_row;
							cursor_col_d = bs_col;
							ram_we       = ({1'b0, bs_row} < (ttw_pkg::ROW_W + 1)'(ttw_pkg::ROWS));
							ram_waddr    = ttw_pkg::cell_addr(bs_row, bs_col);
							ram_wdata    = ttw_pkg::make_cell(ttw_pkg::CH_SPACE, color_q);
						end
					end
					ttw_pkg::OP_PUT_AT: begin
						ram_we    = on_screen;
						ram_waddr = ttw_pkg::cell_addr(row_q, col_q);
						ram_wdata = ttw_pkg::make_cell(char_q, color_in_q);
						oor_d     = !on_screen;
					end
					ttw_pkg::OP_SET_COLOR: begin
						color_d = color_in_q;
					end
					ttw_pkg::OP_CLEAR: begin
						cursor_row_d = '0;
						cursor_col_d = '0;
						color_d      = ttw_pkg::DEFAULT_COLOR;
					end
					ttw_pkg::OP_READ: begin
						ram_re    = on_screen;
						ram_raddr = ttw_pkg::cell_addr(row_q, col_q);
						oor_d     = !on_screen;
					end
					default: begin
					end
				endcase
			end
			ttw_pkg::ST_READ: begin
				data_d = ram_rdata;
			end
			ttw_pkg::ST_SCR_RD: begin
				ram_re = scroll_copy;
			end
			ttw_pkg::ST_SCR_WR: begin
				ram_we    = ({1'b0, cnt_q} < (ttw_pkg::ADDR_W + 1)'(ttw_pkg::CELL_COUNT));
				ram_wdata = scroll_copy ? ram_rdata
					: ttw_pkg::make_cell(ttw_pkg::CH_SPACE, color_q);
				cnt_d     = cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ttw_pkg::ST_BOOT;
			cnt_q        <= '0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			color_q      <= ttw_pkg::DEFAULT_COLOR;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			cnt_q        <= cnt_d;
			cursor_row_q <= cursor_row_d;
			cursor_col_q <= cursor_col_d;
			color_q      <= color_d;
			if (load_rsp) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q       <= req.operation;
			char_q     <= req.char_code;
			row_q      <= req.cell_row;
			col_q      <= req.cell_col;
			color_in_q <= req.color_value;
		end
		data_q <= data_d;
		oor_q  <= oor_d;
		if (load_rsp) begin
			out_data_q <= data_q;
			out_row_q  <= cursor_row_q;
			out_col_q  <= cursor_col_q;
			out_oor_q  <= oor_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.cell_data    = out_data_q;
	assign rsp.cursor_row   = out_row_q;
	assign rsp.cursor_col   = out_col_q;
	assign rsp.out_of_range = out_oor_q;

	ttw_ram #(
		.WIDTH (ttw_pkg::CELL_W),
		.DEPTH (ttw_pkg::CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`TTW_ASSERT_NEXT(a_accept_exec, req.valid && req.ready, st_q == ttw_pkg::ST_EXEC, "request not executed")
	`TTW_ASSERT_NOW(a_idle_no_write, st_q == ttw_pkg::ST_IDLE, !ram_we, "screen write while idle")
	`TTW_ASSERT_NOW(a_cursor_col, 1'b1, {1'b0, cursor_col_q} < (ttw_pkg::COL_W + 1)'(ttw_pkg::COLUMNS), "cursor column off screen")
	`TTW_ASSERT_NOW(a_cursor_row, st_q == ttw_pkg::ST_IDLE, {1'b0, cursor_row_q} < (ttw_pkg::ROW_W + 1)'(ttw_pkg::TEXT_ROWS), "cursor row outside text area")

endmodule

@@ test/text_terminal_writer_tb.sv @@
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives put char, backspace, put at, set color, clear, read and spare
// requests into the writer. A scoreboard keeps its own copy of the screen,
// the cursor and the color, predicts one response per request, and checks
// each response field by field. The random part runs in phases with
// different sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module text_terminal_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttw_pkg::*;

	localparam int QUIET_LIMIT    = 20000;
	localparam int PHASE_REQUESTS = 225;
	localparam int PAGE_PICK      = 100;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              out_of_range;
	} term_result_t;

	class terminal_scoreboard;
		logic [CELL_W-1:0]  screen [CELL_COUNT];
		int                 row_at;
		int                 col_at;
		logic [COLOR_W-1:0] attr_now;
		term_result_t       awaited_q [$];
		int                 errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction

		function void wipe();
			foreach (screen[i]) screen[i] = BLANK_CELL;
			attr_now = DEFAULT_COLOR;
			row_at = 0;
			col_at = 0;
		endfunction

		function void put_cell(int row, int col, logic [CHAR_W-1:0] ch);
			if (row < ROWS && col < COLUMNS) begin
				screen[row * COLUMNS + col] = {attr_now, ch};
			end
		endfunction

		function void scroll_up();
			for (int i = 0; i < (TEXT_ROWS - 1) * COLUMNS; i++) begin
				screen[i] = screen[i + COLUMNS];
			end
			for (int x = 0; x < COLUMNS; x++) put_cell(TEXT_ROWS - 1, x, CH_SPACE);
			row_at = TEXT_ROWS - 1;
		endfunction

		function void type_char(logic [CHAR_W-1:0] ch);
			if (ch == CH_NEWLINE) begin
				col_at = 0;
				row_at++;
			end else if (ch == CH_RETURN) begin
				col_at = 0;
			end else begin
				put_cell(row_at, col_at, ch);
				col_at++;
				if (col_at >= COLUMNS) begin
					col_at = 0;
					row_at++;
				end
			end
			if (row_at >= TEXT_ROWS) scroll_up();
		endfunction

		function void rub_out();
			if (col_at == 0) begin
				if (row_at == 0) return;
				row_at--;
				col_at = COLUMNS - 1;
			end else begin
				col_at--;
			end
			put_cell(row_at, col_at, CH_SPACE);
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
				logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic [COLOR_W-1:0] attr);
			term_result_t r;
			bit           on_screen;
			r = '0;
			on_screen = (row < ROWS) && (col < COLUMNS);
			case (op)
				OP_PUT_CHAR: begin
					type_char(ch);
				end
				OP_BACKSPACE: begin
					rub_out();
				end
				OP_PUT_AT: begin
					if (on_screen) screen[row * COLUMNS + col] = {attr, ch};
					else r.out_of_range = 1'b1;
				end
				OP_SET_COLOR: begin
					attr_now = attr;
				end
				OP_CLEAR: begin
					wipe();
				end
				OP_READ: begin
					if (on_screen) r.cell_data = screen[row * COLUMNS + col];
					else r.out_of_range = 1'b1;
				end
				default: begin
				end
			endcase
			r.cursor_row = row_at[ROW_W-1:0];
			r.cursor_col = col_at[COL_W-1:0];
			awaited_q.push_back(r);
		endfunction

		function void report(string field, logic [CELL_W-1:0] want, logic [CELL_W-1:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s expected %h, got %h", $time, field, want, seen);
			end
		endfunction

		function void check_response(term_result_t got);
			term_result_t want;
			if (awaited_q.size() == 0) begin
				errors++;
				$display("%0t: response with no request waiting, got %h", $time, got);
				return;
			end
			want = awaited_q.pop_front();
			report("cell_data", want.cell_data, got.cell_data);
			report("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
			report("cursor_col", CELL_W'(want.cursor_col), CELL_W'(got.cursor_col));
			report("out_of_range", CELL_W'(want.out_of_range), CELL_W'(got.out_of_range));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ttw_req_if req_ch ();
	ttw_rsp_if rsp_ch ();

	text_terminal_writer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	terminal_scoreboard sb;
	int                 idle_pct;
	int                 stall_pct;
	int                 sent;
	int                 goal;
	int                 quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			sb.check_response({rsp_ch.cell_data, rsp_ch.cursor_row, rsp_ch.cursor_col,
				rsp_ch.out_of_range});
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [CHAR_W-1:0] rnd_char();
		return CHAR_W'($urandom);
	endfunction

	function automatic logic [ROW_W-1:0] rnd_row();
		return ROW_W'($urandom);
	endfunction

	function automatic logic [COL_W-1:0] rnd_col();
		return COL_W'($urandom);
	endfunction

	function automatic logic [COLOR_W-1:0] rnd_attr();
		return COLOR_W'($urandom);
	endfunction

	task automatic send(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic [COLOR_W-1:0] attr);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.char_code   <= ch;
		req_ch.cell_row    <= row;
		req_ch.cell_col    <= col;
		req_ch.color_value <= attr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(op, ch, row, col, attr);
		sent++;
	endtask

	// hold the sender until every response is in
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic random_sequence(int pick);
		int               len;
		int               k;
		bit               in_range;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		if (pick >= PAGE_PICK) begin
			// short lines down the page, enough to force a scroll
			repeat (TEXT_ROWS + 1) begin
				repeat ($urandom_range(3)) begin
					send(OP_PUT_CHAR, rnd_char(), rnd_row(), rnd_col(), rnd_attr());
				end
				send(OP_PUT_CHAR, CH_NEWLINE, rnd_row(), rnd_col(), rnd_attr());
			end
		end else if (pick < 40) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(90, 60) : $urandom_range(24, 1);
			repeat (len) begin
				k = $urandom_range(99);
				send(OP_PUT_CHAR, (k < 2) ? CH_NEWLINE : (k < 4) ? CH_RETURN : 8'($urandom),
					rnd_row(), rnd_col(), rnd_attr());
			end
		end else if (pick < 43) begin
			repeat ($urandom_range(4, 1)) begin
				send(OP_PUT_CHAR, CH_NEWLINE, rnd_row(), rnd_col(), rnd_attr());
			end
		end else if (pick < 56) begin
			repeat ($urandom_range(6, 1)) begin
				in_range = ($urandom_range(99) < 85);
				r = in_range ? ROW_W'($urandom_range(ROWS - 1)) : ROW_W'($urandom);
				c = in_range ? COL_W'($urandom_range(COLUMNS - 1)) : COL_W'($urandom);
				send(OP_PUT_AT, rnd_char(), r, c, rnd_attr());
				if ($urandom_range(1) == 1) send(OP_READ, rnd_char(), r, c, rnd_attr());
			end
		end else if (pick < 71) begin
			repeat ($urandom_range(6, 1)) begin
				k = $urandom_range(9);
				r = (k < 2) ? ROW_W'(TEXT_ROWS - 1) : (k < 3) ? ROW_W'(ROWS - 1) :
					(k < 7) ? ROW_W'($urandom_range(ROWS - 1)) : ROW_W'($urandom);
				c = (k < 7) ? COL_W'($urandom_range(COLUMNS - 1)) : COL_W'($urandom);
				send(OP_READ, rnd_char(), r, c, rnd_attr());
			end
		end else if (pick < 82) begin
			if ($urandom_range(9) < 3) send(OP_PUT_CHAR, CH_NEWLINE, rnd_row(), rnd_col(), rnd_attr());
			repeat ($urandom_range(10, 1)) begin
				send(OP_BACKSPACE, rnd_char(), rnd_row(), rnd_col(), rnd_attr());
			end
		end else if (pick < 88) begin
			send(OP_SET_COLOR, rnd_char(), rnd_row(), rnd_col(), rnd_attr());
		end else if (pick < 91) begin
			send(OP_CLEAR, rnd_char(), rnd_row(), rnd_col(), rnd_attr());
			if ($urandom_range(1) == 1) send(OP_BACKSPACE, rnd_char(), rnd_row(), rnd_col(), rnd_attr());
		end else begin
			send(OP_W'($urandom_range(7)), rnd_char(), rnd_row(), rnd_col(), rnd_attr());
		end
	endtask

	initial begin
		sb = new();
		idle_pct  = 0;
		stall_pct = 0;
		sent      = 0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.operation   <= OP_PUT_CHAR;
		req_ch.char_code   <= '0;
		req_ch.cell_row    <= '0;
		req_ch.cell_col    <= '0;
		req_ch.color_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_BACKSPACE, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_READ, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), 8'h00);
		send(OP_READ, 8'hFF, 5'h1F, 7'h7F, 8'hFF);
		send(OP_READ, 8'h00, ROW_W'(ROWS), 7'd0, 8'h00);
		send(OP_READ, 8'h00, 5'd0, COL_W'(COLUMNS), 8'h00);
		send(OP_PUT_AT, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), 8'hFF);
		send(OP_PUT_AT, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_PUT_AT, 8'h41, 5'h1F, 7'h7F, 8'h1E);
		send(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), 8'h00);
		send(OP_SET_COLOR, 8'h00, 5'd0, 7'd0, 8'hA5);
		send(OP_PUT_CHAR, 8'hFF, 5'd0, 7'd0, 8'h00);
		send(OP_PUT_CHAR, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_PUT_CHAR, CH_RETURN, 5'd0, 7'd0, 8'h00);
		send(OP_PUT_CHAR, 8'h41, 5'd0, 7'd0, 8'h00);
		send(OP_PUT_CHAR, CH_NEWLINE, 5'd0, 7'd0, 8'h00);
		send(OP_BACKSPACE, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_READ, 8'h00, 5'd0, COL_W'(COLUMNS - 1), 8'h00);
		send(OP_SET_COLOR, 8'hFF, 5'h1F, 7'h7F, 8'hFF);
		send(OP_SET_COLOR, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_SPARE_LO, 8'hFF, 5'h1F, 7'h7F, 8'hFF);
		send(OP_SPARE_HI, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00);
		send(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), 8'h00);
		send(OP_READ, 8'h00, 5'd0, 7'd0, 8'h00);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct  = 26;
					stall_pct = 26;
				end
			endcase
			goal = sent + PHASE_REQUESTS;
			random_sequence(PAGE_PICK);
			while (sent < goal) random_sequence($urandom_range(99));
			drain();
		end

		stall_pct = 0;
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

@@ text_terminal_writer.f @@
+incdir+rtl/core
rtl/core/ttw_pkg.sv
rtl/core/ttw_req_if.sv
rtl/core/ttw_rsp_if.sv
rtl/core/ttw_ram.sv
rtl/core/text_terminal_writer.sv
test/text_terminal_writer_tb.sv
